// ===== hw/rtl/kmshid_pkg.sv =====
package kmshid_pkg;

  // Default matrix geometry and report size.
  localparam int RowsDef    = 10;
  localparam int ColumnsDef = 8;
  localparam int MaxKeysDef = 4;

  // A boot report carries at most this many key slots here.
  localparam int SlotCount      = 4;
  localparam int UsageTableSize = 80;

  // Item opcodes.
  localparam logic OpScan   = 1'b0;
  localparam logic OpReport = 1'b1;

  // Bit positions in the control lines.
  localparam int CtlRApple = 2;
  localparam int CtlLApple = 3;
  localparam int CtlCaps   = 4;
  localparam int CtlCtrl   = 5;
  localparam int CtlReset  = 6;
  localparam int CtlShift  = 7;

  // Special usage codes.
  localparam logic [7:0] UsageCaps = 8'd57;
  localparam logic [7:0] UsageF2   = 8'd59;
  localparam logic [7:0] UsageF3   = 8'd60;
  localparam logic [7:0] UsageF4   = 8'd61;
  localparam logic [7:0] UsageF5   = 8'd62;

  // Modifier byte bits.
  localparam logic [7:0] ModCtrl  = 8'h01;
  localparam logic [7:0] ModShift = 8'h02;
  localparam logic [7:0] ModLAlt  = 8'h04;
  localparam logic [7:0] ModRAlt  = 8'h40;

  // Usage code of each key store entry, in scan order.
  localparam logic [7:0] UsageTable [UsageTableSize] = '{
    8'd41, 8'd30, 8'd31, 8'd32, 8'd33, 8'd35, 8'd34, 8'd36, 8'd37, 8'd38,
    8'd43, 8'd20, 8'd26, 8'd8,  8'd21, 8'd28, 8'd23, 8'd24, 8'd12, 8'd18,
    8'd4,  8'd7,  8'd22, 8'd11, 8'd9,  8'd10, 8'd13, 8'd14, 8'd51, 8'd15,
    8'd29, 8'd27, 8'd6,  8'd25, 8'd5,  8'd17, 8'd16, 8'd54, 8'd55, 8'd56,
    8'd56, 8'd81, 8'd30, 8'd31, 8'd32, 8'd33, 8'd49, 8'd46, 8'd39, 8'd45,
    8'd48, 8'd82, 8'd34, 8'd35, 8'd36, 8'd37, 8'd52, 8'd19, 8'd47, 8'd48,
    8'd85, 8'd80, 8'd38, 8'd39, 8'd99, 8'd87, 8'd40, 8'd82, 8'd44, 8'd52,
    8'd41, 8'd79, 8'd48, 8'd86, 8'd88, 8'd54, 8'd42, 8'd81, 8'd80, 8'd79
  };

  // Entries past the table map to usage zero.
  function automatic logic [7:0] usage_of(input logic [7:0] idx);
    logic [7:0] usage;
    usage = 8'd0;
    if (idx < 8'(UsageTableSize)) begin
      usage = UsageTable[idx[6:0]];
    end
    return usage;
  endfunction

  typedef struct packed {
    logic       opcode;
    logic [7:0] row_lines_low;
    logic [7:0] control_lines;
  } kms_in_t;

  typedef struct packed {
    logic [2:0] drive_column;
    logic [7:0] modifier_byte;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [2:0] key_count;
  } kms_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan;
    logic report_start;
    logic walk;
    logic load_out;
  } kms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;
    logic out_free;
  } kms_sts_t;

endpackage

// ===== hw/rtl/keyboard_matrix_scan_hid_report_top.sv =====
// Key matrix scanner and HID boot report builder.
// Input channel: one beat per item, in_data_i.opcode selects a scan step
// (advance row, then column, and store one active-low row line) or a
// report build (caps change, function keys, pressed keys in scan order,
// modifier byte). Each input beat yields exactly one output beat.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// A scan step passes through the StFin state and then the output register.
// A report walks the key store one entry per cycle through its registered
// read port, then passes through StDrain, StFin and the output register.
// One item is in work at a time; in_stall_o is high from the cycle after
// a beat is taken until its result enters the output register.
// The output register lets the next item start while a result waits.
// If the receiver stalls, the result holds and a finished item waits in
// the controller until the output register frees up.
// Reset clears the scan position to row 0, column 0, marks every key as
// released and sets the last caps level to one; no clearing pass is needed.
module keyboard_matrix_scan_hid_report_top #(
  parameter int ROWS     = kmshid_pkg::RowsDef,
  parameter int COLUMNS  = kmshid_pkg::ColumnsDef,
  parameter int MAX_KEYS = kmshid_pkg::MaxKeysDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kmshid_pkg::kms_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output kmshid_pkg::kms_out_t  out_data_o
);
  import kmshid_pkg::*;

  kms_cmd_t cmd;
  kms_sts_t sts;

  // Sequencer for scan and report items.
  kmshid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Key store, scan counters and report registers.
  kmshid_dp #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/kmshid_dp.sv =====
module kmshid_dp #(
  parameter int ROWS     = kmshid_pkg::RowsDef,
  parameter int COLUMNS  = kmshid_pkg::ColumnsDef,
  parameter int MAX_KEYS = kmshid_pkg::MaxKeysDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kmshid_pkg::kms_in_t  in_data_i,
  input  kmshid_pkg::kms_cmd_t cmd_i,
  output kmshid_pkg::kms_sts_t sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output kmshid_pkg::kms_out_t out_data_o
);
  import kmshid_pkg::*;

  localparam int StoreSize = ROWS * COLUMNS;
  localparam int IdxW      = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int CntW      = IdxW + 1;
  localparam int LimitInt  = (MAX_KEYS < SlotCount) ? MAX_KEYS : SlotCount;
  localparam logic [2:0] Limit = 3'(LimitInt);

  // Scan position and report state.
  logic [3:0]          row_q;
  logic [2:0]          col_q;
  logic                caps_last_q;
  logic [7:0]          mod_q;
  logic [2:0]          count_q;
  logic [7:0]          slot_q [SlotCount];
  logic [CntW-1:0]     walk_addr_q;
  logic                rd_pend_q;
  logic [StoreSize-1:0] vld_q;

  // Key store and its registered read port.
  logic                mem_q [StoreSize];
  logic                rd_mem_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_idx_q;

  // Output register.
  logic                out_valid_q;
  kms_out_t            out_q;

  // Next scan position with row and column wrap.
  logic [4:0] row_inc;
  logic [3:0] col_inc;
  logic [3:0] row_n;
  logic [2:0] col_n;
  logic       wr_bit;
  logic [7:0] wr_idx_full;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_addr;

  always_comb begin
    row_inc = {1'b0, row_q} + 5'd1;
    col_inc = {1'b0, col_q} + 4'd1;
    row_n   = row_inc[3:0];
    col_n   = col_q;
    if (row_inc >= 5'(ROWS)) begin
      row_n = 4'd0;
      col_n = (col_inc >= 4'(COLUMNS)) ? 3'd0 : col_inc[2:0];
    end
    // Rows 8 and up come from the control lines.
    wr_bit      = row_n[3] ? in_data_i.control_lines[row_n[2:0]]
                           : in_data_i.row_lines_low[row_n[2:0]];
    wr_idx_full = {5'd0, col_n} * 8'(ROWS) + {4'd0, row_n};
    wr_idx      = wr_idx_full[IdxW-1:0];
  end

  assign rd_addr = walk_addr_q[IdxW-1:0];

  // Report opening: caps change and function keys, then modifiers.
  logic       caps;
  logic [7:0] fkey;
  logic [2:0] init_count;
  logic [7:0] init_slot [SlotCount];
  logic [7:0] init_mod;

  always_comb begin
    caps       = in_data_i.control_lines[CtlCaps];
    init_count = 3'd0;
    for (int s = 0; s < SlotCount; s++) begin
      init_slot[s] = 8'd0;
    end
    if (in_data_i.control_lines[CtlRApple] && in_data_i.control_lines[CtlLApple]) begin
      fkey = UsageF5;
    end else if (in_data_i.control_lines[CtlRApple]) begin
      fkey = UsageF3;
    end else if (in_data_i.control_lines[CtlLApple]) begin
      fkey = UsageF4;
    end else begin
      fkey = UsageF2;
    end
    if ((caps != caps_last_q) && (init_count < Limit)) begin
      init_slot[init_count[1:0]] = UsageCaps;
      init_count = init_count + 3'd1;
    end
    if (!in_data_i.control_lines[CtlReset] && (init_count < Limit)) begin
      init_slot[init_count[1:0]] = fkey;
      init_count = init_count + 3'd1;
    end
    init_mod = 8'd0;
    if (!in_data_i.control_lines[CtlShift]) init_mod = init_mod | ModShift;
    if (!in_data_i.control_lines[CtlCtrl])  init_mod = init_mod | ModCtrl;
    if (in_data_i.control_lines[CtlRApple]) init_mod = init_mod | ModLAlt;
    if (in_data_i.control_lines[CtlLApple]) init_mod = init_mod | ModRAlt;
  end

  // An entry never written since reset reads as released.
  logic key_down;
  assign key_down = rd_vld_q & ~rd_mem_q;

  // Control and report registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= 4'd0;
      col_q       <= 3'd0;
      caps_last_q <= 1'b1;
      vld_q       <= '0;
      walk_addr_q <= '0;
      rd_pend_q   <= 1'b0;
      count_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.walk;
      if (cmd_i.scan) begin
        row_q          <= row_n;
        col_q          <= col_n;
        vld_q[wr_idx]  <= 1'b1;
        count_q        <= 3'd0;
      end
      if (cmd_i.report_start) begin
        caps_last_q <= caps;
        count_q     <= init_count;
        walk_addr_q <= '0;
      end
      if (cmd_i.walk) begin
        walk_addr_q <= walk_addr_q + CntW'(1);
      end
      if (rd_pend_q && key_down && (count_q < Limit)) begin
        count_q <= count_q + 3'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      mod_q <= 8'd0;
      for (int s = 0; s < SlotCount; s++) begin
        slot_q[s] <= 8'd0;
      end
    end
    if (cmd_i.report_start) begin
      mod_q <= init_mod;
      for (int s = 0; s < SlotCount; s++) begin
        slot_q[s] <= init_slot[s];
      end
    end
    if (rd_pend_q && key_down && (count_q < Limit)) begin
      slot_q[count_q[1:0]] <= usage_of({{(8-IdxW){1'b0}}, rd_idx_q});
    end
    if (cmd_i.load_out) begin
      out_q.drive_column  <= col_q;
      out_q.modifier_byte <= mod_q;
      out_q.key_slot0     <= slot_q[0];
      out_q.key_slot1     <= slot_q[1];
      out_q.key_slot2     <= slot_q[2];
      out_q.key_slot3     <= slot_q[3];
      out_q.key_count     <= count_q;
    end
  end

  // Key store: one write port for scans, one registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      mem_q[wr_idx] <= wr_bit;
    end
    if (cmd_i.walk) begin
      rd_mem_q <= mem_q[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  assign sts_o.walk_last = (walk_addr_q == CntW'(StoreSize - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== hw/rtl/kmshid_ctrl.sv =====
module kmshid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  output logic                 in_stall_o,
  output kmshid_pkg::kms_cmd_t cmd_o,
  input  kmshid_pkg::kms_sts_t sts_i
);
  import kmshid_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and datapath commands.
  always_comb begin
    state_d            = state_q;
    cmd_o.scan         = 1'b0;
    cmd_o.report_start = 1'b0;
    cmd_o.walk         = 1'b0;
    cmd_o.load_out     = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (opcode_i == OpReport) begin
            cmd_o.report_start = 1'b1;
            state_d            = StWalk;
          end else begin
            cmd_o.scan = 1'b1;
            state_d    = StFin;
          end
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFin;
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
